// ----- hdl/pwq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pwq_pkg
// Shared codes and control types for the priority wait queue.
// ----------------------------------------------------------------------------
package pwq_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic ins_en;
    logic pop_en;
  } pwq_ctrl_t;

endpackage
`default_nettype wire

// ----- hdl/priority_wait_queue_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// priority_wait_queue_top
// Sorted wait queue of task ids built as a row of compare-and-shift cells.
// The result is registered when the item is accepted and shown in the next cycle.
// Throughput: one insert or pop per cycle unless a held result stalls the input; every cell decides in parallel.
// Reset clears the entry count and the result valid; entries hold no reset.
// ----------------------------------------------------------------------------
module priority_wait_queue_top
  import pwq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PRIORITY_BITS = 8,
  parameter int TASK_BITS     = 8
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire                                   in_op,
  input  wire  [TASK_BITS-1:0]                  in_task_id,
  input  wire  [PRIORITY_BITS-1:0]              in_priority_req,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic [1:0]                            out_status,
  output logic [TASK_BITS-1:0]                  out_task,
  output logic [PRIORITY_BITS-1:0]              out_priority,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]      out_occupancy
);

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [OCC_W-1:0] FULL_CNT = OCC_W'(QUEUE_DEPTH);

  logic                     accept;
  logic                     is_full, is_empty;
  pwq_ctrl_t                ctrl;
  logic [OCC_W-1:0]         count_r, count_nxt;
  logic                     out_valid_r;
  logic [1:0]               status_r, status_nxt;
  logic [TASK_BITS-1:0]     task_r, task_nxt;
  logic [PRIORITY_BITS-1:0] prio_r, prio_nxt;
  logic [OCC_W-1:0]         occ_r;

  logic [QUEUE_DEPTH-1:0]   ge;
  logic [TASK_BITS-1:0]     task_q [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] prio_q [QUEUE_DEPTH];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_full  = (count_r == FULL_CNT);
  assign is_empty = (count_r == '0);

  assign ctrl.ins_en = accept && (in_op == OP_INSERT) && !is_full;
  assign ctrl.pop_en = accept && (in_op == OP_POP) && !is_empty;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam logic [OCC_W-1:0] IDX = OCC_W'(i);
    localparam int LI = (i == 0) ? 0 : i - 1;
    localparam int RI = (i == QUEUE_DEPTH - 1) ? i : i + 1;

    pwq_cell #(
      .PRIORITY_BITS (PRIORITY_BITS),
      .TASK_BITS     (TASK_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (count_r > IDX),
      .new_task   (in_task_id),
      .new_prio   (in_priority_req),
      .left_ge    ((i == 0) ? 1'b0 : ge[LI]),
      .left_task  (task_q[LI]),
      .left_prio  (prio_q[LI]),
      .right_task (task_q[RI]),
      .right_prio (prio_q[RI]),
      .ge         (ge[i]),
      .task_q     (task_q[i]),
      .prio_q     (prio_q[i])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    task_nxt   = '0;
    prio_nxt   = '0;
    unique case (in_op)
      OP_INSERT: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      OP_POP: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
          task_nxt  = task_q[0];
          prio_nxt  = prio_q[0];
        end
      end
      default: status_nxt = ST_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      task_r   <= task_nxt;
      prio_r   <= prio_nxt;
      occ_r    <= count_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_task      = task_r;
  assign out_priority  = prio_r;
  assign out_occupancy = occ_r;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above depth");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == ST_FULL) |-> occ_r == FULL_CNT)
    else $error("full status with queue not full");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_op == OP_POP) && is_empty |=> status_r == ST_EMPTY)
    else $error("pop on empty not flagged");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= OCC_W'(2) |-> prio_q[0] <= prio_q[1])
    else $error("head entries out of order");
`endif

endmodule
`default_nettype wire

// ----- hdl/pwq_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pwq_cell
// One slot of the sorted queue: compares the incoming priority with its own
// entry and keeps it or takes the new entry, its left neighbor, or its right neighbor.
// ----------------------------------------------------------------------------
module pwq_cell
  import pwq_pkg::*;
#(
  parameter int PRIORITY_BITS = 8,
  parameter int TASK_BITS     = 8
) (
  input  wire                      clk,
  input  pwq_ctrl_t                ctrl,
  input  wire                      occupied,
  input  wire  [TASK_BITS-1:0]     new_task,
  input  wire  [PRIORITY_BITS-1:0] new_prio,
  input  wire                      left_ge,
  input  wire  [TASK_BITS-1:0]     left_task,
  input  wire  [PRIORITY_BITS-1:0] left_prio,
  input  wire  [TASK_BITS-1:0]     right_task,
  input  wire  [PRIORITY_BITS-1:0] right_prio,
  output logic                     ge,
  output logic [TASK_BITS-1:0]     task_q,
  output logic [PRIORITY_BITS-1:0] prio_q
);

  logic [TASK_BITS-1:0]     task_r, task_nxt;
  logic [PRIORITY_BITS-1:0] prio_r, prio_nxt;

  // newcomer goes at or ahead of this slot
  assign ge = occupied && (new_prio <= prio_r);

  always_comb begin
    task_nxt = task_r;
    prio_nxt = prio_r;
    priority if (ctrl.pop_en) begin
      task_nxt = right_task;
      prio_nxt = right_prio;
    end else if (ctrl.ins_en) begin
      priority if (left_ge) begin
        task_nxt = left_task;
        prio_nxt = left_prio;
      end else if (ge || !occupied) begin
        task_nxt = new_task;
        prio_nxt = new_prio;
      end else begin
        task_nxt = task_r;
        prio_nxt = prio_r;
      end
    end else begin
      task_nxt = task_r;
      prio_nxt = prio_r;
    end
  end

  always_ff @(posedge clk) begin
    task_r <= task_nxt;
    prio_r <= prio_nxt;
  end

  assign task_q = task_r;
  assign prio_q = prio_r;

endmodule
`default_nettype wire

// ----- sim/pwq_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pwq_checker
// Watches both channels of the priority wait queue. It keeps its own sorted
// copy of the queue, works out the result of every accepted item and checks
// each returned result, field by field, against the oldest one outstanding.
// ----------------------------------------------------------------------------
module pwq_checker
  import pwq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PRIORITY_BITS = 8,
  parameter int TASK_BITS     = 8
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  input  wire                               in_ready,
  input  wire                               in_op,
  input  wire [TASK_BITS-1:0]               in_task_id,
  input  wire [PRIORITY_BITS-1:0]           in_priority_req,
  input  wire                               out_valid,
  input  wire                               out_ready,
  input  wire [1:0]                         out_status,
  input  wire [TASK_BITS-1:0]               out_task,
  input  wire [PRIORITY_BITS-1:0]           out_priority,
  input  wire [$clog2(QUEUE_DEPTH+1)-1:0]   out_occupancy,
  output int                                fail_count,
  output int                                pending,
  output int                                n_results,
  output int                                n_full,
  output int                                n_empty
);

  typedef struct packed {
    logic [1:0]                       status;
    logic [TASK_BITS-1:0]             tid;
    logic [PRIORITY_BITS-1:0]         prio;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] occ;
  } wait_result_t;

  wait_result_t             expected_results[$];
  logic [TASK_BITS-1:0]     held_task[QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] held_prio[QUEUE_DEPTH];
  int                       held_count = 0;
  int                       mismatches = 0;
  int                       checked    = 0;
  int                       full_seen  = 0;
  int                       empty_seen = 0;

  initial pending = 0;

  assign fail_count = mismatches;
  assign n_results  = checked;
  assign n_full     = full_seen;
  assign n_empty    = empty_seen;

  // Sorted insert ahead of equal priorities; pop takes the head.
  function automatic wait_result_t apply_item(input logic op,
                                              input logic [TASK_BITS-1:0] tid,
                                              input logic [PRIORITY_BITS-1:0] prio);
    wait_result_t r;
    int           slot;
    int           i;
    r = '0;
    if (op == OP_INSERT) begin
      if (held_count >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        slot = held_count;
        for (i = held_count - 1; i >= 0; i--) begin
          if (prio <= held_prio[i]) slot = i;
        end
        for (i = held_count; i > slot; i--) begin
          held_task[i] = held_task[i-1];
          held_prio[i] = held_prio[i-1];
        end
        held_task[slot] = tid;
        held_prio[slot] = prio;
        held_count++;
        r.status = ST_DONE;
      end
    end else begin
      if (held_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.status = ST_DONE;
        r.tid    = held_task[0];
        r.prio   = held_prio[0];
        for (i = 1; i < held_count; i++) begin
          held_task[i-1] = held_task[i];
          held_prio[i-1] = held_prio[i];
        end
        held_count--;
      end
    end
    r.occ = ($clog2(QUEUE_DEPTH+1))'(held_count);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    wait_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing outstanding: status %0d task %0d occupancy %0d",
                 out_status, out_task, out_occupancy);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("out_task", 32'(want.tid), 32'(out_task));
          check_field("out_priority", 32'(want.prio), 32'(out_priority));
          check_field("occupancy", 32'(want.occ), 32'(out_occupancy));
          checked++;
          if (want.status == ST_FULL) full_seen++;
          if (want.status == ST_EMPTY) empty_seen++;
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_item(in_op, in_task_id, in_priority_req));
      end
      pending <= expected_results.size();
    end
  end

  final begin
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
    end
  end

endmodule

// ----- sim/priority_wait_queue_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_wait_queue_top_test
// Drives insert and pop items into the priority wait queue with random gaps
// and random back-pressure; the checker predicts and compares every result.
// Directed items cover empty pops, priority extremes, ties and a lone pop;
// random phases swing the queue between full and empty.
// ----------------------------------------------------------------------------
module priority_wait_queue_top_test;
  import pwq_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic       clk             = 1'b0;
  logic       rst_n           = 1'b0;
  logic       in_valid        = 1'b0;
  logic       in_op           = OP_INSERT;
  logic [7:0] in_task_id      = '0;
  logic [7:0] in_priority_req = '0;
  logic       out_ready       = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [1:0] out_status;
  logic [7:0] out_task;
  logic [7:0] out_priority;
  logic [4:0] out_occupancy;

  int fail_count;
  int pending;
  int n_results;
  int n_full;
  int n_empty;
  int n_inserts   = 0;
  int n_pops      = 0;
  int stall_count = 0;
  bit calm        = 1'b0;

  priority_wait_queue_top i_dut (.*);

  pwq_checker i_checker (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 28);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("** priority_wait_queue_top: FAILED **");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  task automatic push_item(input logic op, input logic [7:0] tid, input logic [7:0] prio);
    in_valid        <= 1'b1;
    in_op           <= op;
    in_task_id      <= tid;
    in_priority_req <= prio;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_INSERT) n_inserts++;
    else n_pops++;
    if (!calm && $urandom_range(99) < 28) begin
      in_valid        <= 1'b0;
      in_op           <= 1'($urandom_range(1));
      in_task_id      <= 8'($urandom);
      in_priority_req <= 8'($urandom);
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
  endtask

  task automatic drain_queue();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int ins_pct;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    push_item(OP_POP, 8'h00, 8'h00);
    push_item(OP_INSERT, 8'hFF, 8'hFF);
    push_item(OP_INSERT, 8'h00, 8'h00);
    push_item(OP_INSERT, 8'hAA, 8'h80);
    push_item(OP_INSERT, 8'h55, 8'h80);
    push_item(OP_INSERT, 8'h3C, 8'hFF);
    push_item(OP_INSERT, 8'hC3, 8'h00);
    repeat (6) push_item(OP_POP, 8'($urandom), 8'($urandom));
    push_item(OP_POP, 8'hFF, 8'hFF);
    push_item(OP_INSERT, 8'h5A, 8'hA5);
    push_item(OP_POP, 8'h00, 8'h00);
    repeat (17) push_item(OP_INSERT, 8'($urandom), 8'($urandom_range(255, 254)));
    repeat (17) push_item(OP_POP, 8'h00, 8'h00);

    for (int phase = 0; phase < 14; phase++) begin
      case (phase % 4)
        0: ins_pct = 85;
        1: ins_pct = 50;
        2: ins_pct = 15;
        default: ins_pct = 65;
      endcase
      calm = (phase == 6);
      for (int k = 0; k < 50; k++) begin
        if ($urandom_range(99) < ins_pct) begin
          push_item(OP_INSERT, 8'($urandom),
                    (phase % 2) ? 8'($urandom_range(3)) : 8'($urandom_range(255)));
        end else begin
          push_item(OP_POP, 8'($urandom), 8'($urandom));
        end
      end
      if (phase == 8) drain_queue();
    end
    calm = 1'b0;

    drain_queue();
    repeat (10) @(posedge clk);
    $display("Sent %0d items: %0d inserts, %0d pops; checked %0d results.",
             n_inserts + n_pops, n_inserts, n_pops, n_results);
    $display("Results seen: %0d inserts refused on a full queue, %0d pops on empty.",
             n_full, n_empty);
    if (fail_count == 0) begin
      $display("** priority_wait_queue_top: PASSED **");
    end else begin
      $display("** priority_wait_queue_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/pwq_pkg.sv
hdl/pwq_cell.sv
hdl/priority_wait_queue_top.sv
sim/pwq_checker.sv
sim/priority_wait_queue_top_test.sv
